FILE: hw/rtl/chbt_pkg.sv
// Package for the chained hash bucket table.
// Holds defaults, status and operation codes and the beat structs.
// No dependencies.
package chbt_pkg;

  localparam int unsigned DEF_BUCKET_COUNT = 256;
  localparam int unsigned DEF_POOL_NODES   = 1024;
  localparam int unsigned DEF_KEY_BITS     = 64;
  localparam int unsigned DEF_VALUE_BITS   = 64;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_GET    = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_EXISTS    = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_EXHAUSTED = 2'd3;

  typedef struct packed {
    logic [1:0]  operation;
    logic [7:0]  bucket;
    logic [63:0] key;
    logic [63:0] value;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] result_value;
    logic [10:0] probe_length;
  } rsp_t;

endpackage

FILE: hw/rtl/chained_hash_bucket_table_unit.sv
// Chained hash bucket table, top level.
// Depends on chbt_pkg.
//
// Usage:
//  - req channel (req_valid/req_ready/req) carries one request beat:
//    operation, bucket index, key and value. rsp channel carries one result
//    beat per request: status, stored value, probe_length.
//  - Each request walks its bucket chain in the node memory, node by node
//    (read, then compare and follow the link); a hit ends the walk at that
//    node, a miss walks to the chain end. Unused operation codes skip the
//    walk and go straight to the finishing step.
//  - Requests are taken one at a time. A new request is taken while the
//    previous result still waits in the output register; the block then
//    holds at its finishing step until that result beat has gone.
//  - Reset clears the bucket valid bits (every chain empty), sets the free
//    count to the pool size and the free-stack low-water mark to the pool
//    size, so entries below the mark read as their own index. No clearing
//    pass is needed; the block takes requests in the cycle after reset.
//  - A stalled receiver only stops the finishing step; no state changes
//    until the result can be loaded.
module chained_hash_bucket_table_unit
  import chbt_pkg::*;
#(
  parameter int unsigned BUCKET_COUNT = DEF_BUCKET_COUNT,
  parameter int unsigned POOL_NODES   = DEF_POOL_NODES,
  parameter int unsigned KEY_BITS     = DEF_KEY_BITS,
  parameter int unsigned VALUE_BITS   = DEF_VALUE_BITS
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  // node reference width includes the null marker (POOL_NODES)
  localparam int unsigned NW = $clog2(POOL_NODES + 1);
  localparam int unsigned IW = (POOL_NODES > 1) ? $clog2(POOL_NODES) : 1;
  localparam int unsigned BW = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1;
  localparam int unsigned PW = $clog2(POOL_NODES + 2);
  localparam logic [NW-1:0] NIL  = NW'(POOL_NODES);
  localparam logic [NW-1:0] POOL = NW'(POOL_NODES);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_HEAD  = 3'd1;
  localparam logic [2:0] S_WALK  = 3'd2;
  localparam logic [2:0] S_CHECK = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;

  // bucket reduction table for the 8-bit index
  typedef logic [BW-1:0] bmod_t [256];
  function automatic bmod_t make_bmod();
    bmod_t r;
    for (int i = 0; i < 256; i++) r[i] = BW'(i % BUCKET_COUNT);
    return r;
  endfunction
  localparam bmod_t BMOD = make_bmod();

  // memories
  logic [NW-1:0]         heads_mem [BUCKET_COUNT];
  logic [KEY_BITS-1:0]   key_mem   [POOL_NODES];
  logic [VALUE_BITS-1:0] val_mem   [POOL_NODES];
  logic [NW-1:0]         link_mem  [POOL_NODES];
  logic [IW-1:0]         stack_mem [POOL_NODES];
  logic [BUCKET_COUNT-1:0] head_vld;

  // control and request registers
  logic [2:0]            state;
  logic [1:0]            op;
  logic [BW-1:0]         bkt;
  logic [KEY_BITS-1:0]   key_q;
  logic [VALUE_BITS-1:0] val_q;
  logic [NW-1:0]         head, cur, prev;
  logic [PW-1:0]         probes;
  logic                  found;
  logic [NW-1:0]         hit, hit_link;
  logic [VALUE_BITS-1:0] hit_val;
  logic [NW-1:0]         free_count, low_mark;

  // registered read data
  logic [NW-1:0]         head_rd;
  logic                  head_rd_vld;
  logic [KEY_BITS-1:0]   key_rd;
  logic [VALUE_BITS-1:0] val_rd;
  logic [NW-1:0]         link_rd;
  logic [IW-1:0]         stack_rd;

  logic [BW-1:0] b_addr;
  logic [NW-1:0] fc_m1;
  logic [NW-1:0] popped;
  logic          fin_go;
  logic          accept;
  rsp_t          res;

  assign req_ready = (state == S_IDLE);
  assign accept    = req_valid && req_ready;
  assign b_addr    = (state == S_IDLE) ? BMOD[req.bucket] : bkt;
  assign fc_m1     = free_count - NW'(1);
  assign fin_go    = (state == S_FIN) && (!rsp_valid || rsp_ready);
  // entries below the low-water mark were never written: they hold their index
  assign popped    = (fc_m1 < low_mark) ? fc_m1 : NW'(stack_rd);

  always_ff @(posedge clk) begin
    head_rd     <= heads_mem[b_addr];
    head_rd_vld <= head_vld[b_addr];
    key_rd      <= key_mem[cur[IW-1:0]];
    val_rd      <= val_mem[cur[IW-1:0]];
    link_rd     <= link_mem[cur[IW-1:0]];
    stack_rd    <= stack_mem[fc_m1[IW-1:0]];
  end

  // finishing result, formed from the walk outcome
  always_comb begin
    res = '0;
    res.status       = ST_NOT_FOUND;
    res.probe_length = 11'(probes);
    unique case (op)
      OP_INSERT: begin
        if (found) res.status = ST_EXISTS;
        else if (free_count == '0) res.status = ST_EXHAUSTED;
        else res.status = ST_OK;
      end
      OP_GET: begin
        if (found) begin
          res.status       = ST_OK;
          res.result_value = 64'(hit_val);
        end
      end
      OP_REMOVE: if (found) res.status = ST_OK;
      default: begin
        res.probe_length = 11'd1;
      end
    endcase
  end

  // memory writes, only at the finishing step
  always_ff @(posedge clk) begin
    if (fin_go) begin
      if (op == OP_INSERT && !found && free_count != '0) begin
        key_mem[popped[IW-1:0]]  <= key_q;
        val_mem[popped[IW-1:0]]  <= val_q;
        link_mem[popped[IW-1:0]] <= head;
        heads_mem[bkt]           <= popped;
      end
      if (op == OP_REMOVE && found) begin
        if (prev == NIL) heads_mem[bkt] <= hit_link;
        else link_mem[prev[IW-1:0]] <= hit_link;
        if (free_count < POOL) stack_mem[free_count[IW-1:0]] <= hit[IW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      head_vld   <= '0;
      free_count <= POOL;
      low_mark   <= POOL;
      rsp_valid  <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) rsp_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            op     <= req.operation;
            bkt    <= BMOD[req.bucket];
            key_q  <= req.key[KEY_BITS-1:0];
            val_q  <= req.value[VALUE_BITS-1:0];
            found  <= 1'b0;
            prev   <= NIL;
            probes <= PW'(1);
            state  <= (req.operation == OP_INSERT || req.operation == OP_GET ||
                       req.operation == OP_REMOVE) ? S_HEAD : S_FIN;
          end
        end
        S_HEAD: begin
          head  <= head_rd_vld ? head_rd : NIL;
          cur   <= head_rd_vld ? head_rd : NIL;
          state <= S_WALK;
        end
        S_WALK: begin
          // node read for cur is in flight; stop at the chain end or bound
          if (cur >= POOL || probes > PW'(POOL_NODES)) state <= S_FIN;
          else state <= S_CHECK;
        end
        S_CHECK: begin
          if (key_rd == key_q) begin
            found    <= 1'b1;
            hit      <= cur;
            hit_link <= link_rd;
            hit_val  <= val_rd;
            state    <= S_FIN;
          end else begin
            prev   <= cur;
            cur    <= link_rd;
            probes <= probes + PW'(1);
            state  <= S_WALK;
          end
        end
        S_FIN: begin
          if (fin_go) begin
            rsp_valid <= 1'b1;
            rsp       <= res;
            state     <= S_IDLE;
            if (op == OP_INSERT && !found && free_count != '0) begin
              head_vld[bkt] <= 1'b1;
              free_count    <= fc_m1;
              if (fc_m1 < low_mark) low_mark <= fc_m1;
            end
            if (op == OP_REMOVE && found) begin
              if (prev == NIL) head_vld[bkt] <= 1'b1;
              if (free_count < POOL) free_count <= free_count + NW'(1);
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: dv/chbt_checker.sv
// Checker for the chained hash bucket table: watches both channels, predicts each result.
// Depends on chbt_pkg.
module chbt_checker
  import chbt_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  input  logic req_ready,
  input  req_t req,
  input  logic rsp_valid,
  input  logic rsp_ready,
  input  rsp_t rsp,
  output int   fail_count,
  output int   pending
);

  localparam int NB = DEF_BUCKET_COUNT;
  localparam int NP = DEF_POOL_NODES;

  logic [10:0] head_of [NB];
  logic [63:0] key_of  [NP];
  logic [63:0] val_of  [NP];
  logic [10:0] link_of [NP];
  logic [9:0]  free_stk [NP];
  int          free_n;
  rsp_t        expected_q [$];

  assign pending = expected_q.size();

  function automatic rsp_t table_apply(req_t r);
    rsp_t o;
    logic [10:0] cur, prev, hit;
    int n, steps;
    bit found;
    int b;
    o.status = ST_NOT_FOUND;
    o.result_value = '0;
    o.probe_length = 11'd1;
    b = r.bucket % NB;
    if (r.operation > OP_REMOVE) return o;
    cur = head_of[b];
    prev = NP[10:0];
    hit = NP[10:0];
    n = 1;
    steps = 0;
    found = 0;
    while (cur < NP && steps < NP && !found) begin
      if (key_of[cur] == r.key) begin
        found = 1;
        hit = cur;
      end else begin
        prev = cur;
        cur = link_of[cur];
        n++;
        steps++;
      end
    end
    o.probe_length = n[10:0];
    case (r.operation)
      OP_INSERT: begin
        if (found) o.status = ST_EXISTS;
        else if (free_n == 0) o.status = ST_EXHAUSTED;
        else begin
          int nd;
          free_n--;
          nd = free_stk[free_n];
          key_of[nd] = r.key;
          val_of[nd] = r.value;
          link_of[nd] = head_of[b];
          head_of[b] = nd[10:0];
          o.status = ST_OK;
        end
      end
      OP_GET: begin
        if (found) begin
          o.status = ST_OK;
          o.result_value = val_of[hit];
        end
      end
      default: begin
        if (found) begin
          if (prev >= NP) head_of[b] = link_of[hit];
          else link_of[prev] = link_of[hit];
          if (free_n < NP) begin
            free_stk[free_n] = hit[9:0];
            free_n++;
          end
          o.status = ST_OK;
        end
      end
    endcase
    return o;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NB; i++) head_of[i] = NP[10:0];
      for (int i = 0; i < NP; i++) free_stk[i] = i[9:0];
      free_n = NP;
      expected_q.delete();
      fail_count <= 0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result beat %h", $time, rsp);
          fail_count <= fail_count + 1;
        end else begin
          rsp_t e;
          e = expected_q.pop_front();
          if (e.status !== rsp.status || e.result_value !== rsp.result_value ||
              e.probe_length !== rsp.probe_length) begin
            $display("%0t: mismatch exp st=%0d val=%h pl=%0d got st=%0d val=%h pl=%0d",
                     $time, e.status, e.result_value, e.probe_length,
                     rsp.status, rsp.result_value, rsp.probe_length);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (req_valid && req_ready) expected_q.push_back(table_apply(req));
    end
  end

endmodule

FILE: dv/testbench.sv
// Testbench top for the chained hash bucket table: stimulus, idling and verdict.
// Depends on chbt_pkg, chbt_checker and the block itself.
module testbench;
  import chbt_pkg::*;

  logic clk = 0;
  logic rst = 1;
  logic req_valid = 0;
  logic req_ready;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 0;
  rsp_t rsp;
  int   fail_count;
  int   pending;
  int   cycle_count = 0;
  bit   quiet = 0;      // last part of the run: no idling on either side
  bit   hold_off = 0;   // long receiver stall

  always #4 clk = ~clk;

  chained_hash_bucket_table_unit dut (
    .clk(clk), .rst(rst), .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
  );

  chbt_checker chk (
    .clk(clk), .rst(rst), .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
    .fail_count(fail_count), .pending(pending)
  );

  // Keys kept small in number so gets and removes hit and chains grow long.
  logic [63:0] key_pool [16];

  // Guard against a hung block: far above the slowest correct run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 20000000) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Receiver: random stall bursts, plus one long hold-off.
  initial begin
    int burst;
    @(posedge clk iff !rst);
    forever begin
      if (hold_off) begin
        rsp_ready <= 0;
        repeat (400) @(posedge clk);
        hold_off = 0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        burst = $urandom_range(1, 9);
        rsp_ready <= 0;
        repeat (burst) @(posedge clk);
      end else begin
        rsp_ready <= 1;
        @(posedge clk);
      end
    end
  end

  // One request beat; valid stays high until accepted.
  task automatic send_beat(logic [1:0] op, logic [7:0] b, logic [63:0] k, logic [63:0] v);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      req_valid <= 0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    req_valid <= 1;
    req <= '{operation: op, bucket: b, key: k, value: v};
    @(posedge clk);
    while (!req_ready) @(posedge clk);
  endtask

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  initial begin
    logic [1:0] op;
    logic [7:0] b;
    for (int i = 0; i < 16; i++) key_pool[i] = rnd64();
    key_pool[0] = '0;
    key_pool[1] = '1;
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // directed: extremes, every operation, unused code, head and mid removal
    send_beat(OP_GET, 8'd0, 64'd0, 64'd0);
    send_beat(OP_INSERT, 8'd0, 64'd0, '1);
    send_beat(OP_INSERT, 8'd0, 64'd0, 64'd5);
    send_beat(OP_INSERT, 8'd0, '1, 64'd0);
    send_beat(OP_INSERT, 8'd0, 64'h55, 64'hAA);
    send_beat(OP_GET, 8'd0, 64'd0, 64'd1);
    send_beat(OP_GET, 8'd0, '1, 64'd0);
    send_beat(OP_REMOVE, 8'd0, '1, 64'd0);
    send_beat(OP_REMOVE, 8'd0, 64'h55, 64'd0);
    send_beat(OP_REMOVE, 8'd0, 64'h55, 64'd0);
    send_beat(OP_UNUSED, 8'd0, 64'd0, 64'd0);
    send_beat(OP_UNUSED, 8'hFF, '1, '1);
    send_beat(OP_INSERT, 8'hFF, '1, '1);
    send_beat(OP_GET, 8'hFF, '1, 64'd0);
    send_beat(OP_REMOVE, 8'd0, 64'd0, 64'd0);
    send_beat(OP_GET, 8'd0, 64'd0, 64'd0);
    // long receiver stall while requests keep coming
    hold_off = 1;
    for (int i = 0; i < 20; i++) send_beat(OP_INSERT, 8'd7, rnd64(), rnd64());
    // fill the pool to reach exhaustion
    for (int i = 0; i < 1030; i++)
      send_beat(OP_INSERT, 8'($urandom_range(0, 255)), rnd64(), rnd64());
    send_beat(OP_INSERT, 8'd3, rnd64(), rnd64());
    // random traffic over a few buckets and a small key set
    for (int i = 0; i < 140; i++) begin
      if (i == 110) quiet = 1;
      op = ($urandom_range(0, 19) == 0) ? OP_UNUSED : 2'($urandom_range(0, 2));
      if (i < 100 && $urandom_range(0, 1)) op = OP_REMOVE;
      b = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255)) :
                                        8'($urandom_range(0, 3));
      send_beat(op, b, ($urandom_range(0, 5) == 0) ? rnd64() : key_pool[$urandom_range(0, 15)],
                rnd64());
    end
    req_valid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fail_count == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
